// ===== sv/lkvc_pkg.sv =====
package lkvc_pkg;

	localparam int CAPACITY_MAX_DEF = 16;
	localparam int CFG_W            = 5;
	localparam int KEY_W            = 16;
	localparam int DATA_W           = 32;
	localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

	typedef struct packed {
		logic                     func;
		logic [KEY_W-1:0]         key;
		logic signed [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_AGE    = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

endpackage

// ===== sv/lru_key_value_cache.sv =====
// channel | direction | valid     | stall     | payload
// request | in        | req_valid | req_stall | req (func, key, write_value)
// result  | out       | rsp_valid | rsp_stall | rsp (hit, read_value)
// config  | in        | cfg_we    | -         | cfg_wdata (capacity)
// an item passes a scan, a decide step and an aging pass before its result
// shows, a get miss skips the aging pass: one entry per cycle through a single
// key compare and age compare, once to search and once to age the entries.
// reset clears valid marks, ages, fill count and sets capacity to 16.
// req_stall is high from acceptance until the result item is taken.
module lru_key_value_cache
	import lkvc_pkg::*;
#(
	parameter int CAPACITY_MAX = CAPACITY_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int IDX_W = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
	localparam int CNT_W = $clog2(CAPACITY_MAX + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY_MAX - 1);
	localparam logic [CMP_W-1:0] CAP_LIMIT = CMP_W'(CAPACITY_MAX);

	state_t state_q;

	logic [CFG_W-1:0] capacity_q;
	req_t             req_q;
	rsp_t             rsp_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] used_q;

	logic              valid_q [CAPACITY_MAX];
	logic [IDX_W-1:0]  age_q   [CAPACITY_MAX];
	logic [KEY_W-1:0]  key_q   [CAPACITY_MAX];
	logic [DATA_W-1:0] data_q  [CAPACITY_MAX];

	logic             found_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] slot_age_q;
	logic             any_q;
	logic [IDX_W-1:0] best_q;
	logic [IDX_W-1:0] best_age_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_q;
	logic [IDX_W-1:0] target_q;
	logic [IDX_W-1:0] thr_q;
	logic             inc_all_q;

	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] eff_cap;
	logic             full;
	logic             is_put;
	logic             do_evict;
	logic             do_write;
	logic [IDX_W-1:0] wr_slot;
	logic             idx_last;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = (state_q == ST_OUT);
	assign rsp       = rsp_q;
	assign idx_last  = (idx_q == IDX_LAST);
	assign is_put    = (req_q.func == FUNC_PUT);

	// effective capacity, clamped to 1 .. CAPACITY_MAX
	always_comb begin
		cap_ext = CMP_W'(capacity_q);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CAP_LIMIT) begin
			eff_cap = CAP_LIMIT;
		end else begin
			eff_cap = cap_ext;
		end
		full     = (CMP_W'(used_q) >= eff_cap);
		do_evict = full && any_q;
		do_write = is_put;
		if (found_q) begin
			wr_slot = slot_q;
		end else if (do_evict) begin
			wr_slot = best_q;
		end else begin
			wr_slot = free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			used_q       <= '0;
			found_q      <= 1'b0;
			any_q        <= 1'b0;
			free_found_q <= 1'b0;
			inc_all_q    <= 1'b0;
			for (int i = 0; i < CAPACITY_MAX; i++) begin
				valid_q[i] <= 1'b0;
				age_q[i]   <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q      <= ST_SCAN;
						idx_q        <= '0;
						found_q      <= 1'b0;
						any_q        <= 1'b0;
						free_found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (valid_q[idx_q] && key_q[idx_q] == req_q.key && !found_q) begin
						found_q <= 1'b1;
					end
					if (valid_q[idx_q] && (!any_q || age_q[idx_q] > best_age_q)) begin
						any_q <= 1'b1;
					end
					if (!valid_q[idx_q] && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (idx_last) begin
						state_q <= ST_DECIDE;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_DECIDE: begin
					idx_q <= '0;
					if (!found_q && !is_put) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_AGE;
						if (found_q) begin
							inc_all_q <= 1'b0;
						end else if (do_evict) begin
							inc_all_q <= 1'b0;
						end else begin
							// fresh insert: every other valid entry ages
							inc_all_q        <= 1'b1;
							valid_q[free_q]  <= 1'b1;
							used_q           <= used_q + 1'b1;
						end
						age_q[wr_slot] <= '0;
					end
				end
				ST_AGE: begin
					if (valid_q[idx_q] && idx_q != target_q &&
						(inc_all_q || age_q[idx_q] < thr_q)) begin
						age_q[idx_q] <= age_q[idx_q] + 1'b1;
					end
					if (idx_last) begin
						state_q <= ST_OUT;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_OUT: begin
					if (!rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload capture, scan bookkeeping, and response and entry writes
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == ST_SCAN) begin
			if (valid_q[idx_q] && key_q[idx_q] == req_q.key && !found_q) begin
				slot_q     <= idx_q;
				slot_age_q <= age_q[idx_q];
			end
			if (valid_q[idx_q] && (!any_q || age_q[idx_q] > best_age_q)) begin
				best_q     <= idx_q;
				best_age_q <= age_q[idx_q];
			end
			if (!valid_q[idx_q] && !free_found_q) begin
				free_q <= idx_q;
			end
		end
		if (state_q == ST_DECIDE) begin
			target_q  <= wr_slot;
			thr_q     <= found_q ? slot_age_q : best_age_q;
			rsp_q.hit <= found_q;
			if (is_put) begin
				rsp_q.read_value <= '0;
			end else if (found_q) begin
				rsp_q.read_value <= data_q[slot_q];
			end else begin
				rsp_q.read_value <= MISS_VALUE;
			end
			if (do_write) begin
				data_q[wr_slot] <= req_q.write_value;
				key_q[wr_slot]  <= req_q.key;
			end
		end
	end

endmodule
